@@ rtl/csvft_pkg.sv @@
// csvft_pkg: types, codes and helpers shared by the CSV field tokeniser.
// Used by csvft_ctrl, csvft_dp and csv_field_tokenizer_top; no dependencies.
package csvft_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       field_end;
    logic       line_end;
    logic       ws_dropped;
    logic       run_last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RELEASE,
    ST_PEND
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // take the input transaction
    logic rel_step;   // emit the current held byte
    logic emit_pend;  // emit the byte that followed the held run
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_ready;  // output register can be loaded this cycle
    logic need_rel;   // presented item releases held whitespace first
    logic rel_last;   // current held byte is the last of the run
  } dp_status_t;

  // space, tab, LF, VT, FF, CR
  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage

@@ rtl/csv_field_tokenizer_top.sv @@
// csv_field_tokenizer_top: CSV line tokeniser, byte in, trimmed field bytes out.
// Depends on csvft_pkg, csvft_ctrl, csvft_dp and csvft_ram.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction per line
// byte, or an end-of-line command. Output channel (out_valid_o / out_stall_i /
// out_data_o): content bytes in order, a field-end item after each field, with
// line_end on the last field of a line and run_last on the final item caused
// by an input transaction.
// A result is registered and appears in the output register in the cycle after
// its input is taken. When held whitespace is released first, taking the input
// reads the first held byte from the store; the held bytes then follow one per
// cycle while the output is not stalled, then the byte itself. Throughput is one
// input per cycle unless the output stalls or held whitespace is being released.
// Quotes (bar one quote byte per doubled quote) and leading and held whitespace
// give no output. Reset clears quoting and field state and empties the pending
// store; no clearing pass is needed. A stall on the output holds the output
// register and the release sequence; the input is stalled until the register can be loaded.
module csv_field_tokenizer_top #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  csvft_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output csvft_pkg::out_item_t  out_data_o
);

  csvft_pkg::ctrl_cmd_t  cmd;
  csvft_pkg::dp_status_t status;

  csvft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  csvft_dp #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/csvft_ram.sv @@
// csvft_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module csvft_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/csvft_ctrl.sv @@
// csvft_ctrl: sequencer for the tokeniser; decides when to take an input
// transaction and steps the release of held whitespace. Depends on csvft_pkg.
module csvft_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  csvft_pkg::dp_status_t  status_i,
  output csvft_pkg::ctrl_cmd_t   cmd_o
);

  csvft_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csvft_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      csvft_pkg::ST_IDLE: begin
        in_stall_o = !status_i.out_ready;
        if (in_valid_i && status_i.out_ready) begin
          cmd_o.accept = 1'b1;
          if (status_i.need_rel) begin
            state_d = csvft_pkg::ST_RELEASE;
          end
        end
      end
      csvft_pkg::ST_RELEASE: begin
        if (status_i.out_ready) begin
          cmd_o.rel_step = 1'b1;
          if (status_i.rel_last) begin
            state_d = csvft_pkg::ST_PEND;
          end
        end
      end
      csvft_pkg::ST_PEND: begin
        if (status_i.out_ready) begin
          cmd_o.emit_pend = 1'b1;
          state_d         = csvft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = csvft_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/csvft_dp.sv @@
// csvft_dp: tokeniser datapath; quote decoding, field state, held whitespace
// store and output register. Depends on csvft_pkg and csvft_ram.
module csvft_dp #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  csvft_pkg::in_item_t    in_data_i,
  input  csvft_pkg::ctrl_cmd_t   cmd_i,
  output csvft_pkg::dp_status_t  status_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output csvft_pkg::out_item_t   out_data_o
);

  localparam int CntW  = $clog2(PENDING_DEPTH + 1);
  localparam int AddrW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam logic [CntW-1:0] DepthC = CntW'(PENDING_DEPTH);

  logic            quoted_q, quoted_d;
  logic            qseen_q, qseen_d;
  logic            started_q, started_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] held_cnt_q, held_cnt_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [7:0]      pend_byte_q, pend_byte_d;
  logic            out_valid_q, out_valid_d;
  csvft_pkg::out_item_t out_q, out_d;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_rdata;

  // item decode
  logic            is_eol, take, close_fld, qm_eff, qm_next, qs_next, cont_sp;
  logic [7:0]      cont;
  logic [CntW-1:0] rd_next;
  logic            out_ready, out_load;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign rd_next   = rd_idx_q + CntW'(1);

  always_comb begin
    is_eol    = (in_data_i.cmd == csvft_pkg::CMD_EOL);
    take      = 1'b0;
    close_fld = 1'b0;
    qm_eff    = quoted_q;
    qm_next   = quoted_q;
    qs_next   = 1'b0;
    cont      = in_data_i.char_byte;
    if (qseen_q && in_data_i.char_byte == csvft_pkg::CH_QUOTE) begin
      // doubled quote inside quotes: one literal quote
      take = 1'b1;
    end else begin
      if (qseen_q) begin
        qm_eff  = 1'b0;
        qm_next = 1'b0;
      end
      if (in_data_i.char_byte == csvft_pkg::CH_QUOTE) begin
        if (qm_eff) begin
          qs_next = 1'b1;
        end else begin
          qm_next = 1'b1;
        end
      end else if (in_data_i.char_byte == csvft_pkg::CH_COMMA && !qm_eff) begin
        close_fld = 1'b1;
      end else begin
        take = 1'b1;
      end
    end
    cont_sp = csvft_pkg::is_space(cont);
  end

  always_comb begin
    status_o.out_ready = out_ready;
    status_o.need_rel  = !is_eol && take && !cont_sp && started_q &&
                         (held_cnt_q != '0);
    status_o.rel_last  = (rd_next == held_cnt_q);
  end

  always_comb begin
    quoted_d    = quoted_q;
    qseen_d     = qseen_q;
    started_d   = started_q;
    ovf_d       = ovf_q;
    held_cnt_d  = held_cnt_q;
    rd_idx_d    = rd_idx_q;
    pend_byte_d = pend_byte_q;
    out_d       = out_q;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = held_cnt_q[AddrW-1:0];
    ram_re      = 1'b0;
    ram_raddr   = '0;

    if (cmd_i.accept) begin
      if (is_eol) begin
        out_d      = '{has_byte: 1'b0, out_byte: 8'h00, field_end: 1'b1,
                       line_end: 1'b1, ws_dropped: ovf_q, run_last: 1'b1};
        out_load   = 1'b1;
        quoted_d   = 1'b0;
        qseen_d    = 1'b0;
        started_d  = 1'b0;
        held_cnt_d = '0;
        ovf_d      = 1'b0;
      end else begin
        quoted_d = qm_next;
        qseen_d  = qs_next;
        if (close_fld) begin
          out_d      = '{has_byte: 1'b0, out_byte: 8'h00, field_end: 1'b1,
                         line_end: 1'b0, ws_dropped: ovf_q, run_last: 1'b1};
          out_load   = 1'b1;
          started_d  = 1'b0;
          held_cnt_d = '0;
          ovf_d      = 1'b0;
        end else if (take) begin
          if (cont_sp) begin
            // leading whitespace is dropped silently
            if (started_q) begin
              if (held_cnt_q < DepthC) begin
                ram_we     = 1'b1;
                held_cnt_d = held_cnt_q + CntW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
          end else if (status_o.need_rel) begin
            pend_byte_d = cont;
            rd_idx_d    = '0;
            ram_re      = 1'b1;
          end else begin
            out_d      = '{has_byte: 1'b1, out_byte: cont, field_end: 1'b0,
                           line_end: 1'b0, ws_dropped: 1'b0, run_last: 1'b1};
            out_load   = 1'b1;
            started_d  = 1'b1;
            held_cnt_d = '0;
          end
        end
      end
    end

    if (cmd_i.rel_step) begin
      out_d    = '{has_byte: 1'b1, out_byte: ram_rdata, field_end: 1'b0,
                   line_end: 1'b0, ws_dropped: 1'b0, run_last: 1'b0};
      out_load = 1'b1;
      if (!status_o.rel_last) begin
        rd_idx_d  = rd_next;
        ram_re    = 1'b1;
        ram_raddr = rd_next[AddrW-1:0];
      end
    end

    if (cmd_i.emit_pend) begin
      out_d      = '{has_byte: 1'b1, out_byte: pend_byte_q, field_end: 1'b0,
                     line_end: 1'b0, ws_dropped: 1'b0, run_last: 1'b1};
      out_load   = 1'b1;
      held_cnt_d = '0;
      started_d  = 1'b1;
    end

    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q    <= 1'b0;
      qseen_q     <= 1'b0;
      started_q   <= 1'b0;
      ovf_q       <= 1'b0;
      held_cnt_q  <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      quoted_q    <= quoted_d;
      qseen_q     <= qseen_d;
      started_q   <= started_d;
      ovf_q       <= ovf_d;
      held_cnt_q  <= held_cnt_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
    out_q       <= out_d;
  end

  csvft_ram #(
    .Width (8),
    .Depth (PENDING_DEPTH)
  ) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cont),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
